// ===== design/dq_pkg.sv =====
// shared types and constants of the double-ended queue
package dq_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_QUERY      = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell, at most one bit set
  typedef struct packed {
    logic push_back;
    logic push_front;
    logic pop_front;
    logic pop_back;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== design/double_ended_queue.sv =====
// top level of the double-ended queue: command decode, cell chain and result register
//
// usage
//   s_axis carries one operation per transaction: op code and a data word.
//   m_axis returns one result per operation: front word, back word, entry
//   count, empty flag and status (ok, push rejected as full, pop rejected
//   as empty). front and back words read as zero while the queue is empty.
// timing and throughput
//   the result of an operation is registered at the accepting edge and is
//   valid on m_axis from the next cycle. one operation is taken every
//   clock while no result is held back on m_axis; the whole cell row is
//   updated at once, each cell looking at its two neighbors, the command and the input word.
// reset
//   rst (synchronous, active high) clears every occupied flag and the
//   count, so the queue starts empty; no result is pending after reset.
// stall
//   a held result stays on m_axis until taken; s_axis_tready drops only
//   while a result waits and m_axis_tready is low.
module double_ended_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // op[2:0], value[34:3], zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // first_value[31:0], last_value[63:32],
                                      // entry_count[68:64], is_empty[69],
                                      // status[71:70]
);

  // input fields
  dq_pkg::op_t               op;
  logic [dq_pkg::DATA_W-1:0] value;

  // handshake
  logic accept;

  // queue state: the row of cells is front-aligned, cell 0 holds the front
  logic [dq_pkg::DATA_W-1:0] cell_data      [dq_pkg::DEPTH];
  logic [dq_pkg::DATA_W-1:0] cell_data_next [dq_pkg::DEPTH];
  logic [dq_pkg::DEPTH-1:0]  occ;
  logic [dq_pkg::DEPTH-1:0]  occ_next;
  logic [dq_pkg::DEPTH-1:0]  tail_mark;
  logic [dq_pkg::CNT_W-1:0]  held_count;
  logic [dq_pkg::CNT_W-1:0]  held_count_next;

  // command decode
  dq_pkg::cell_ctl_t ctl;
  dq_pkg::status_t   status_next;
  logic              full;
  logic              empty;

  // result assembly
  logic [dq_pkg::DATA_W-1:0] first_next;
  logic [dq_pkg::DATA_W-1:0] last_next;

  // result register
  logic [dq_pkg::DATA_W-1:0] first_value;
  logic [dq_pkg::DATA_W-1:0] last_value;
  logic [dq_pkg::CNT_W-1:0]  entry_count;
  logic                      is_empty;
  dq_pkg::status_t           status;

  assign op    = dq_pkg::op_t'(s_axis_tdata[2:0]);
  assign value = s_axis_tdata[34:3];

  // output register frees up in the same cycle it is drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full  = occ[dq_pkg::DEPTH-1];
  assign empty = !occ[0];

  always_comb begin
    ctl             = '0;
    status_next     = dq_pkg::ST_OK;
    held_count_next = held_count;
    case (op)
      dq_pkg::OP_PUSH_BACK, dq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = dq_pkg::ST_FULL;
        end else begin
          ctl.push_back   = (op == dq_pkg::OP_PUSH_BACK);
          ctl.push_front  = (op == dq_pkg::OP_PUSH_FRONT);
          held_count_next = held_count + 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          ctl.pop_front   = (op == dq_pkg::OP_POP_FRONT);
          ctl.pop_back    = (op == dq_pkg::OP_POP_BACK);
          held_count_next = held_count - 1'b1;
        end
      end
      dq_pkg::OP_CLEAR: begin
        ctl.clear       = 1'b1;
        held_count_next = '0;
      end
      default: begin
        // query and unused codes leave the queue as it is
      end
    endcase
    // nothing moves unless a transaction is taken
    if (!accept) begin
      ctl = '0;
    end
  end

  // chain of cells; the front cell sees the incoming word as its left
  // neighbor, the back cell sees an empty right neighbor
  for (genvar i = 0; i < dq_pkg::DEPTH; i++) begin : g_cell
    logic [dq_pkg::DATA_W-1:0] prev_data;
    logic                      prev_occ;
    logic [dq_pkg::DATA_W-1:0] next_data;
    logic                      next_occ;

    if (i == 0) begin : g_front
      assign prev_data = value;
      assign prev_occ  = 1'b1;
    end else begin : g_mid_l
      assign prev_data = cell_data[i-1];
      assign prev_occ  = occ[i-1];
    end

    if (i == dq_pkg::DEPTH - 1) begin : g_back
      assign next_data = '0;
      assign next_occ  = 1'b0;
    end else begin : g_mid_r
      assign next_data = cell_data[i+1];
      assign next_occ  = occ[i+1];
    end

    dq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .value     (value),
      .prev_data (prev_data),
      .prev_occ  (prev_occ),
      .next_data (next_data),
      .next_occ  (next_occ),
      .data      (cell_data[i]),
      .occ       (occ[i]),
      .data_next (cell_data_next[i]),
      .occ_next  (occ_next[i])
    );
  end

  // the back entry is the last occupied cell of the row
  assign tail_mark = occ_next & ~(occ_next >> 1);

  always_comb begin
    first_next = occ_next[0] ? cell_data_next[0] : '0;
    last_next  = '0;
    for (int i = 0; i < dq_pkg::DEPTH; i++) begin
      last_next = last_next | ({dq_pkg::DATA_W{tail_mark[i]}} & cell_data_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        held_count    <= held_count_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_value <= first_next;
      last_value  <= last_next;
      entry_count <= held_count_next;
      is_empty    <= (held_count_next == '0);
      status      <= status_next;
    end
  end

  assign m_axis_tdata = {status, is_empty, entry_count, last_value, first_value};

`ifndef SYNTH
  // occupied flags and the count register must agree
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(occ) == held_count)
    else $error("occupied cells disagree with entry count");

  // occupied cells form one unbroken run from the front
  a_front_aligned: assert property (@(posedge clk) disable iff (rst)
    (occ & (occ + 1'b1)) == '0)
    else $error("gap in the occupied cells");

  // a full rejection is only reported with a full queue
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status == dq_pkg::ST_FULL) |-> (entry_count == dq_pkg::DEPTH))
    else $error("full status with room left");

  // an accepted push into a non-full queue adds exactly one entry
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !full && (op == dq_pkg::OP_PUSH_BACK || op == dq_pkg::OP_PUSH_FRONT))
    |=> (held_count == $past(held_count) + 1'b1))
    else $error("push did not add one entry");
`endif

endmodule

// ===== design/dq_cell.sv =====
// one storage cell of the queue chain, holds one entry and its occupied flag
module dq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  dq_pkg::cell_ctl_t           ctl,
  input  logic [dq_pkg::DATA_W-1:0]   value,
  input  logic [dq_pkg::DATA_W-1:0]   prev_data,
  input  logic                        prev_occ,
  input  logic [dq_pkg::DATA_W-1:0]   next_data,
  input  logic                        next_occ,
  output logic [dq_pkg::DATA_W-1:0]   data,
  output logic                        occ,
  output logic [dq_pkg::DATA_W-1:0]   data_next,
  output logic                        occ_next
);

  always_comb begin
    data_next = data;
    occ_next  = occ;
    if (ctl.clear) begin
      occ_next = 1'b0;
    end else if (ctl.push_front) begin
      // whole row moves one cell toward the back
      data_next = prev_data;
      occ_next  = prev_occ;
    end else if (ctl.pop_front) begin
      // whole row moves one cell toward the front
      data_next = next_data;
      occ_next  = next_occ;
    end else if (ctl.push_back) begin
      if (!occ && prev_occ) begin
        data_next = value;
        occ_next  = 1'b1;
      end
    end else if (ctl.pop_back) begin
      if (occ && !next_occ) begin
        occ_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

endmodule
